/* rtl/wrsa_pkg.sv */
// package for the weighted random select with aging block
// constants for field widths, defaults and reset values; no dependencies
package wrsa_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int WEIGHT_BITS_DEF = 24;
  localparam int WORD_BITS       = 32;
  localparam int STEP_BITS       = 16;
  localparam int OUT_BITS        = 4;

  localparam logic [STEP_BITS-1:0] AGING_RESET = 16'd1000;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [STEP_BITS-1:0] step_t;
  typedef logic [OUT_BITS-1:0]  index_out_t;

endpackage

/* rtl/wrsa_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module wrsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/weighted_random_select_with_aging_top.sv */
// Weighted random select with aging: each transfer on the input channel
// brings a 32-bit random word; the block reduces it modulo the sum of all
// weights (kept in a running-total register), then walks the weight ram once,
// choosing the first entry whose prefix sum exceeds the remainder, writing 1
// back to it and adding aging_step (saturating) to every other entry. Each item
// passes through the bit-serial modulo unit, then the ram read-modify-write
// pass (one read per entry, each followed by its write-back, and a closing
// step), and then loads the output register. The next item can be taken in the
// cycle after the result is loaded, so a new item is never taken before the last
// one's result is loaded. Input is taken only while the block is idle; a finished
// result may wait in the output register while the next item is worked on, and
// a second finished result waits until the first one is taken. After reset the
// weights read as 1 through per-entry valid bits, so no clearing pass runs.
// Depends on wrsa_pkg and wrsa_ram.
module weighted_random_select_with_aging_top #(
  parameter int ENTRIES     = wrsa_pkg::ENTRIES_DEF,
  parameter int WEIGHT_BITS = wrsa_pkg::WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wrsa_pkg::word_t       in_random_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output wrsa_pkg::index_out_t  out_chosen_index,
  input  logic                  cfg_wr_en,
  input  wrsa_pkg::step_t       cfg_wr_data
);

  import wrsa_pkg::*;

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam int SUM_BITS = WEIGHT_BITS + IDX_BITS;
  localparam int GW       = ((WEIGHT_BITS > STEP_BITS) ? WEIGHT_BITS : STEP_BITS) + 1;
  localparam int BIT_BITS = $clog2(WORD_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

  logic [1:0]             state_r, state_nxt;
  step_t                  step_r;
  logic [SUM_BITS-1:0]    total_r, total_nxt;
  logic [SUM_BITS-1:0]    rem_r, rem_nxt;
  word_t                  word_r, word_nxt;
  logic [BIT_BITS-1:0]    bit_r, bit_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                   rv_r, rv_nxt;
  logic                   vb_r, vb_nxt;
  logic [IDX_BITS-1:0]    wa_r, wa_nxt;
  logic [SUM_BITS-1:0]    prefix_r, prefix_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_BITS-1:0]    pick_r, pick_nxt;
  logic [ENTRIES-1:0]     valid_r, valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  index_out_t             out_idx_r, out_idx_nxt;

  logic [SUM_BITS:0]      trial;
  logic [IDX_BITS-1:0]    rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [WEIGHT_BITS-1:0] w_cur;
  logic [GW-1:0]          grown;
  logic [WEIGHT_BITS-1:0] w_aged;
  logic [WEIGHT_BITS-1:0] w_new;
  logic                   is_pick;
  logic                   wr_en;

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;

  assign rd_addr = cnt_r[IDX_BITS-1:0];
  assign trial   = {rem_r, word_r[WORD_BITS-1]};
  assign w_cur   = vb_r ? rd_data : WEIGHT_BITS'(1);
  assign grown   = GW'(w_cur) + GW'(step_r);
  assign w_aged  = (grown > GW'(WMAX)) ? WMAX : grown[WEIGHT_BITS-1:0];
  assign is_pick = !found_r && ((prefix_r + SUM_BITS'(w_cur)) > rem_r);
  assign w_new   = is_pick ? WEIGHT_BITS'(1) : w_aged;
  assign wr_en   = rv_r;

  wrsa_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (ENTRIES)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wa_r),
    .wr_data (w_new),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    rv_nxt        = 1'b0;
    vb_nxt        = vb_r;
    wa_nxt        = wa_r;
    prefix_nxt    = prefix_r;
    sum_nxt       = sum_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_random_word;
          rem_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, total_r}) begin
          rem_nxt = SUM_BITS'(trial - {1'b0, total_r});
        end else begin
          rem_nxt = trial[SUM_BITS-1:0];
        end
        word_nxt = word_r << 1;
        bit_nxt  = bit_r + 1'b1;
        if (bit_r == BIT_BITS'(WORD_BITS - 1)) begin
          cnt_nxt    = '0;
          prefix_nxt = '0;
          sum_nxt    = '0;
          found_nxt  = 1'b0;
          pick_nxt   = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r < CNT_BITS'(ENTRIES)) begin
          rv_nxt  = 1'b1;
          wa_nxt  = rd_addr;
          vb_nxt  = valid_r[rd_addr];
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rv_r) begin
          prefix_nxt     = prefix_r + SUM_BITS'(w_cur);
          sum_nxt        = sum_r + SUM_BITS'(w_new);
          valid_nxt[wa_r] = 1'b1;
          if (is_pick) begin
            found_nxt = 1'b1;
            pick_nxt  = wa_r;
          end
        end
        if ((cnt_r == CNT_BITS'(ENTRIES)) && !rv_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = OUT_BITS'(pick_r);
          total_nxt     = sum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= AGING_RESET;
      total_r     <= SUM_BITS'(ENTRIES);
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      bit_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      rv_r        <= rv_nxt;
      found_r     <= found_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      bit_r       <= bit_nxt;
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    word_r    <= word_nxt;
    vb_r      <= vb_nxt;
    wa_r      <= wa_nxt;
    prefix_r  <= prefix_nxt;
    sum_r     <= sum_nxt;
    pick_r    <= pick_nxt;
    out_idx_r <= out_idx_nxt;
  end

`ifndef SYNTHESIS
  a_total_floor: assert property (@(posedge clk) disable iff (!rst_n)
    total_r >= SUM_BITS'(ENTRIES))
    else $error("weight total below entry count");

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DIV))
    else $error("accepted transfer did not start the modulo");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rem_r < total_r))
    else $error("remainder not below weight total");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> found_r)
    else $error("pass ended without a chosen entry");
`endif

endmodule

/* dv/wrsa_lottery_checker.sv */
`timescale 1ns / 1ps
// checker for weighted_random_select_with_aging_top: keeps its own weight table,
// predicts the chosen index of every input transfer and compares result transfers
// depends on wrsa_pkg only
module wrsa_lottery_checker #(
  parameter int ENTRIES     = wrsa_pkg::ENTRIES_DEF,
  parameter int WEIGHT_BITS = wrsa_pkg::WEIGHT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  wrsa_pkg::word_t      in_random_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  wrsa_pkg::index_out_t out_chosen_index,
  input  logic                 cfg_wr_en,
  input  wrsa_pkg::step_t      cfg_wr_data,
  output int                   mismatch_count,
  output int                   picks_pending
);

  import wrsa_pkg::*;

  localparam longint unsigned WEIGHT_MAX = (64'd1 << WEIGHT_BITS) - 64'd1;

  logic [WEIGHT_BITS-1:0] weights [ENTRIES];
  step_t                  aging;
  index_out_t             expected_picks [$];

  function automatic index_out_t draw_and_age(word_t w);
    longint unsigned total;
    longint unsigned rem;
    longint unsigned running;
    longint unsigned grown;
    int              winner;
    total   = 0;
    running = 0;
    winner  = 0;
    for (int k = 0; k < ENTRIES; k++) total += weights[k];
    if (total != 0) begin
      rem = {32'd0, w} % total;
      for (int k = 0; k < ENTRIES; k++) begin
        running += weights[k];
        if (running > rem) begin
          winner = k;
          break;
        end
      end
    end
    for (int k = 0; k < ENTRIES; k++) begin
      if (k == winner) begin
        weights[k] = WEIGHT_BITS'(1);
      end else begin
        grown = longint'(weights[k]) + longint'(aging);
        weights[k] = (grown > WEIGHT_MAX) ? WEIGHT_MAX[WEIGHT_BITS-1:0]
                                          : grown[WEIGHT_BITS-1:0];
      end
    end
    return index_out_t'(winner);
  endfunction

  always @(posedge clk) begin
    index_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) weights[k] = WEIGHT_BITS'(1);
      aging = AGING_RESET;
      expected_picks.delete();
    end else begin
      if (cfg_wr_en) aging = cfg_wr_data;
      // pop before push: a result never belongs to the item taken at the same edge
      if (out_valid && !out_stall) begin
        if (expected_picks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: chosen_index %0d", out_chosen_index);
        end else begin
          want = expected_picks.pop_front();
          if (out_chosen_index !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("chosen_index mismatch: expected %0d actual %0d",
                       want, out_chosen_index);
          end
        end
      end
      if (in_valid && !in_stall) expected_picks.push_back(draw_and_age(in_random_word));
    end
    picks_pending = expected_picks.size();
  end

endmodule

/* dv/weighted_random_select_with_aging_top_tb.sv */
`timescale 1ns / 1ps
// testbench top for weighted_random_select_with_aging_top: clock, reset, stimulus
// and verdict; depends on wrsa_pkg, the block and wrsa_lottery_checker
module weighted_random_select_with_aging_top_tb;
  import wrsa_pkg::*;

  localparam int SETTLE_CYCLES = ENTRIES_DEF + 40;
  localparam int STALL_LIMIT   = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  word_t      in_random_word;
  logic       out_valid;
  logic       out_stall;
  index_out_t out_chosen_index;
  logic       cfg_wr_en;
  step_t      cfg_wr_data;
  int         mismatch_count;
  int         picks_pending;
  logic       steady;
  int         quiet_cycles;

  weighted_random_select_with_aging_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_random_word   (in_random_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chosen_index (out_chosen_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  wrsa_lottery_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_random_word   (in_random_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chosen_index (out_chosen_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .picks_pending    (picks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_word(input word_t w);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_random_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_picks();
    in_valid <= 1'b0;
    while (picks_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_aging(input step_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0, 1:    return word_t'($urandom_range(0, 63));
      2:       return 32'hFFFF_FFFF - word_t'($urandom_range(0, 63));
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count, input int zero_run, input int steady_run);
    for (int i = 0; i < count; i++) begin
      steady = (i < steady_run);
      // long runs of zero always pick entry 0 and push the rest into saturation
      send_word(i < zero_run ? 32'd0 : random_word());
    end
    steady = 1'b0;
  endtask

  initial begin
    word_t reset_words [11];
    word_t flat_words [8];
    reset_words = '{32'd15, 32'd16, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1,
                    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF,
                    32'hFFFF_0000};
    flat_words  = '{32'd0, 32'd14, 32'd15, 32'd16, 32'd17, 32'd31,
                    32'hFFFF_FFF0, 32'hFFFF_FFFF};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_random_word = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    steady         = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset aging step, first pick from the all-ones table
    foreach (reset_words[i]) send_word(reset_words[i]);
    drain_picks();

    // zero step: table settles to all ones, picks land on exact prefix edges
    write_aging('0);
    foreach (flat_words[i]) send_word(flat_words[i]);
    random_phase(200, 0, 0);
    drain_picks();

    write_aging(16'hFFFF);
    random_phase(350, 260, 0);
    drain_picks();

    write_aging(step_t'($urandom_range(1, 65534)));
    random_phase(400, 0, 150);
    drain_picks();

    write_aging(16'd1);
    random_phase(300, 0, 0);
    drain_picks();

    write_aging(step_t'($urandom_range(0, 65535)));
    random_phase(250, 0, 0);
    drain_picks();

    if (mismatch_count == 0 && picks_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/wrsa_pkg.sv
rtl/wrsa_ram.sv
rtl/weighted_random_select_with_aging_top.sv
dv/wrsa_lottery_checker.sv
dv/weighted_random_select_with_aging_top_tb.sv
